/* design/rrqs_pkg.sv */
// Package: sizes, event codes and queue entry type for the round-robin scheduler.
`default_nettype none

package rrqs_pkg;

    // Ready queue depth and width of the remaining-time counter
    localparam int QUEUE_SLOTS = 16;
    localparam int TIME_BITS   = 16;

    localparam int PTR_W  = $clog2(QUEUE_SLOTS);
    localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);

    // Fixed port field widths
    localparam int ID_W    = 4;
    localparam int RT_W    = 16;
    localparam int EV_W    = 3;
    localparam int QUANT_W = 8;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(3);

    // Input opcodes
    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_FINISHED  = 3'd1,
        EV_PREEMPTED = 3'd2,
        EV_ADMITTED  = 3'd3,
        EV_REJECTED  = 3'd4
    } event_t;

    // One ready queue slot
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] left;
    } queue_entry_t;

    // Circular pointer advance
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

/* design/round_robin_quantum_scheduler.sv */
// Top level: round-robin time-slice scheduler with its ready queue in a synchronous RAM.
// Flow: the item is latched at its transfer and executed in the S_EXEC state; the result
// is registered at the end of that execute step, where m_valid rises.
// Only one item is in flight: no new item is taken until the last one is executed and the
// output register is free; each item waits for the registered read of the queue head first.
// Reset: control state, pointers, fill count and running process are cleared and
// quantum returns to 3; the queue RAM is not cleared (a slot's read data is only used once written).
`default_nettype none

module round_robin_quantum_scheduler
    import rrqs_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_opcode,
    input  wire  [ID_W-1:0]     s_process_id,
    input  wire  [RT_W-1:0]     s_run_time,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [EV_W-1:0]     m_event_res,
    output logic [ID_W-1:0]     m_event_id,
    output logic                m_running_valid,
    output logic [ID_W-1:0]     m_running_id,
    output logic [RT_W-1:0]     m_remaining,

    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [QUANT_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [QUANT_W-1:0] quantum_reg;

    // Latched item
    logic                 op_reg;
    logic [ID_W-1:0]      pid_reg;
    logic [TIME_BITS-1:0] rt_reg;
    logic [31:0]          rt_wide;

    // Scheduler state
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 active_reg, active_next;
    logic [ID_W-1:0]      proc_reg, proc_next;
    logic [TIME_BITS-1:0] left_reg, left_next;
    logic [QUANT_W-1:0]   slice_reg, slice_next;

    // Queue RAM
    queue_entry_t         queue_mem [QUEUE_SLOTS];
    queue_entry_t         rd_data_reg;
    queue_entry_t         wr_data;
    logic                 rd_en;
    logic                 wr_en;
    logic                 pop;

    // Output register
    logic                 m_valid_reg;
    event_t               ev_next;
    logic [ID_W-1:0]      ev_id_next;
    event_t               ev_reg;
    logic [ID_W-1:0]      ev_id_reg;
    logic                 run_valid_reg;
    logic [ID_W-1:0]      run_id_reg;
    logic [RT_W-1:0]      remaining_reg;
    logic [31:0]          left_wide;

    logic s_xfer;
    logic m_xfer;

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;

    // One item in flight; take a new one when the output register frees up
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign rd_en   = s_xfer;

    assign rt_wide = 32'(s_run_time);

    // Quantum register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            quantum_reg <= cfg_data;
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg  <= s_opcode;
            pid_reg <= s_process_id;
            rt_reg  <= rt_wide[TIME_BITS-1:0];
        end
    end

    // Queue RAM: head read at item transfer, tail write during execute
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= queue_mem[head_reg];
        end
        if (wr_en) begin
            queue_mem[tail_reg] <= wr_data;
        end
    end

    // FSM next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Scheduling step
    always_comb begin
        logic [QUANT_W-1:0] slice_inc;
        logic               q_full;
        logic               q_empty;

        slice_inc = slice_reg + QUANT_W'(1);
        q_full    = (fill_reg == FILL_W'(QUEUE_SLOTS));
        q_empty   = (fill_reg == '0);

        active_next = active_reg;
        proc_next   = proc_reg;
        left_next   = left_reg;
        slice_next  = slice_reg;
        ev_next     = EV_NONE;
        ev_id_next  = '0;
        wr_en       = 1'b0;
        wr_data     = '{id: pid_reg, left: rt_reg};
        pop         = 1'b0;

        if (state_reg == S_EXEC) begin
            if (op_reg == OP_CREATE) begin
                ev_id_next = pid_reg;
                if (!active_reg) begin
                    active_next = 1'b1;
                    proc_next   = pid_reg;
                    left_next   = rt_reg;
                    slice_next  = '0;
                    ev_next     = EV_ADMITTED;
                end else if (q_full) begin
                    ev_next = EV_REJECTED;
                end else begin
                    wr_en   = 1'b1;
                    ev_next = EV_ADMITTED;
                end
            end else if (active_reg) begin
                if (left_reg <= TIME_BITS'(1)) begin
                    // Finish; dispatch the head if anything waits
                    ev_next    = EV_FINISHED;
                    ev_id_next = proc_reg;
                    slice_next = '0;
                    if (!q_empty) begin
                        pop       = 1'b1;
                        proc_next = rd_data_reg.id;
                        left_next = rd_data_reg.left;
                    end else begin
                        active_next = 1'b0;
                        proc_next   = '0;
                        left_next   = '0;
                    end
                end else begin
                    left_next  = left_reg - TIME_BITS'(1);
                    slice_next = slice_inc;
                    if (slice_inc == quantum_reg) begin
                        slice_next = '0;
                        if (!q_empty) begin
                            // Preempt: head runs, old process goes to the tail
                            pop        = 1'b1;
                            wr_en      = 1'b1;
                            wr_data    = '{id: proc_reg, left: left_reg - TIME_BITS'(1)};
                            proc_next  = rd_data_reg.id;
                            left_next  = rd_data_reg.left;
                            ev_next    = EV_PREEMPTED;
                            ev_id_next = proc_reg;
                        end
                    end
                end
            end
        end

        head_next = pop   ? next_ptr(head_reg) : head_reg;
        tail_next = wr_en ? next_ptr(tail_reg) : tail_reg;
        fill_next = fill_reg + FILL_W'(wr_en) - FILL_W'(pop);
    end

    // Control and scheduler state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            active_reg <= 1'b0;
            proc_reg   <= '0;
            left_reg   <= '0;
            slice_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
            proc_reg   <= proc_next;
            left_reg   <= left_next;
            slice_reg  <= slice_next;
        end
    end

    // Output register
    assign left_wide = 32'(left_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EXEC) begin
            m_valid_reg <= 1'b1;
        end else if (m_xfer) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC) begin
            ev_reg        <= ev_next;
            ev_id_reg     <= ev_id_next;
            run_valid_reg <= active_next;
            run_id_reg    <= active_next ? proc_next : '0;
            remaining_reg <= active_next ? left_wide[RT_W-1:0] : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = ev_reg;
    assign m_event_id      = ev_id_reg;
    assign m_running_valid = run_valid_reg;
    assign m_running_id    = run_id_reg;
    assign m_remaining     = remaining_reg;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(QUEUE_SLOTS))
        else $error("ready queue fill exceeds depth");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0 || fill_reg == FILL_W'(QUEUE_SLOTS)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with fill count");

    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> !m_valid_reg)
        else $error("execute step with output register still occupied");

    a_xfer_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_EXEC))
        else $error("accepted item not executed next cycle");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !run_valid_reg) |-> (run_id_reg == '0 && remaining_reg == '0))
        else $error("idle processor reports a running process");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> fill_reg != '0)
        else $error("dispatch from empty ready queue");

endmodule

`default_nettype wire

/* tb/sched_checker.sv */
// Checker: predicts the scheduler's result for every input transfer and compares it.
`timescale 1ns / 100ps

module sched_checker
    import rrqs_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                s_valid,
    input  wire                s_ready,
    input  wire                s_opcode,
    input  wire  [ID_W-1:0]    s_process_id,
    input  wire  [RT_W-1:0]    s_run_time,

    input  wire                m_valid,
    input  wire                m_ready,
    input  wire  [EV_W-1:0]    m_event_res,
    input  wire  [ID_W-1:0]    m_event_id,
    input  wire                m_running_valid,
    input  wire  [ID_W-1:0]    m_running_id,
    input  wire  [RT_W-1:0]    m_remaining,

    input  wire                cfg_valid,
    input  wire                cfg_ready,
    input  wire  [QUANT_W-1:0] cfg_data,

    output int                 mismatches,
    output int                 outstanding
);

    // One predicted result transfer
    typedef struct packed {
        event_t               ev;
        logic [ID_W-1:0]      ev_id;
        logic                 run_valid;
        logic [ID_W-1:0]      run_id;
        logic [TIME_BITS-1:0] left;
    } sched_result_t;

    // Predicted scheduler state
    logic [ID_W-1:0]      slot_id   [QUEUE_SLOTS];
    logic [TIME_BITS-1:0] slot_left [QUEUE_SLOTS];
    logic [PTR_W-1:0]     rd_ptr;
    logic [PTR_W-1:0]     wr_ptr;
    int                   waiting;
    logic                 busy;
    logic [ID_W-1:0]      cur_id;
    logic [TIME_BITS-1:0] cur_left;
    logic [QUANT_W-1:0]   slices;
    logic [QUANT_W-1:0]   quantum;

    sched_result_t        expected_events[$];
    sched_result_t        predicted;
    sched_result_t        oldest;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Append a process behind every waiting one
    task automatic append_waiting(input logic [ID_W-1:0] id, input logic [TIME_BITS-1:0] left);
        slot_id[wr_ptr]   = id;
        slot_left[wr_ptr] = left;
        wr_ptr            = PTR_W'((int'(wr_ptr) + 1) % QUEUE_SLOTS);
        waiting++;
    endtask

    // Put the oldest waiting process on the processor with a fresh slice
    task automatic start_next_waiting();
        cur_id   = slot_id[rd_ptr];
        cur_left = slot_left[rd_ptr];
        busy     = 1'b1;
        slices   = '0;
        rd_ptr   = PTR_W'((int'(rd_ptr) + 1) % QUEUE_SLOTS);
        waiting--;
    endtask

    task automatic predict_schedule(input logic op, input logic [ID_W-1:0] pid,
                                    input logic [RT_W-1:0] rt, output sched_result_t r);
        logic [ID_W-1:0]      old_id;
        logic [TIME_BITS-1:0] old_left;
        r.ev    = EV_NONE;
        r.ev_id = '0;
        if (op == OP_CREATE) begin
            r.ev_id = pid;
            if (!busy) begin
                busy     = 1'b1;
                cur_id   = pid;
                cur_left = TIME_BITS'(rt);
                slices   = '0;
                r.ev     = EV_ADMITTED;
            end else if (waiting >= QUEUE_SLOTS) begin
                r.ev = EV_REJECTED;
            end else begin
                append_waiting(pid, TIME_BITS'(rt));
                r.ev = EV_ADMITTED;
            end
        end else if (busy) begin
            slices = slices + QUANT_W'(1);
            // finishing wins over slice expiry; zero time finishes like one
            if (cur_left <= TIME_BITS'(1)) begin
                r.ev     = EV_FINISHED;
                r.ev_id  = cur_id;
                busy     = 1'b0;
                cur_id   = '0;
                cur_left = '0;
                slices   = '0;
                if (waiting > 0)
                    start_next_waiting();
            end else begin
                cur_left = cur_left - TIME_BITS'(1);
                // 8-bit count wraps, so a quantum of zero expires every 256 ticks
                if (slices == quantum) begin
                    slices = '0;
                    if (waiting > 0) begin
                        old_id   = cur_id;
                        old_left = cur_left;
                        start_next_waiting();
                        append_waiting(old_id, old_left);
                        r.ev     = EV_PREEMPTED;
                        r.ev_id  = old_id;
                    end
                end
            end
        end
        r.run_valid = busy;
        r.run_id    = busy ? cur_id : '0;
        r.left      = busy ? cur_left : '0;
    endtask

    // Compare results first: a result never belongs to an item of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr   = '0;
            wr_ptr   = '0;
            waiting  = 0;
            busy     = 1'b0;
            cur_id   = '0;
            cur_left = '0;
            slices   = '0;
            quantum  = QUANTUM_RESET;
            expected_events.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                quantum = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected result, event_res", int'(m_event_res), -1);
                end else begin
                    oldest = expected_events.pop_front();
                    if (m_event_res !== oldest.ev)
                        report_mismatch("event_res", int'(m_event_res), int'(oldest.ev));
                    if (m_event_id !== oldest.ev_id)
                        report_mismatch("event_id", int'(m_event_id), int'(oldest.ev_id));
                    if (m_running_valid !== oldest.run_valid)
                        report_mismatch("running_valid", int'(m_running_valid),
                                        int'(oldest.run_valid));
                    if (m_running_id !== oldest.run_id)
                        report_mismatch("running_id", int'(m_running_id), int'(oldest.run_id));
                    if (m_remaining !== oldest.left)
                        report_mismatch("remaining", int'(m_remaining), int'(oldest.left));
                end
            end
            if (s_valid && s_ready) begin
                predict_schedule(s_opcode, s_process_id, s_run_time, predicted);
                expected_events.push_back(predicted);
            end
        end
        outstanding = expected_events.size();
    end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, stimulus and verdict for the round-robin scheduler.
`timescale 1ns / 100ps

module tb_top;
    import rrqs_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    logic               aclk;
    logic               aresetn         = 1'b0;

    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_opcode        = OP_CREATE;
    logic [ID_W-1:0]    s_process_id    = '0;
    logic [RT_W-1:0]    s_run_time      = '0;

    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [EV_W-1:0]    m_event_res;
    logic [ID_W-1:0]    m_event_id;
    logic               m_running_valid;
    logic [ID_W-1:0]    m_running_id;
    logic [RT_W-1:0]    m_remaining;

    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [QUANT_W-1:0] cfg_data        = '0;

    int                 mismatches;
    int                 outstanding;
    int                 idle_cycles     = 0;
    int                 burst_left      = 0;
    bit                 sender_fast     = 1'b0;

    round_robin_quantum_scheduler dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_process_id    (s_process_id),
        .s_run_time      (s_run_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_event_id      (m_event_id),
        .m_running_valid (m_running_valid),
        .m_running_id    (m_running_id),
        .m_remaining     (m_remaining),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    sched_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_process_id    (s_process_id),
        .s_run_time      (s_run_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_event_id      (m_event_id),
        .m_running_valid (m_running_valid),
        .m_running_id    (m_running_id),
        .m_remaining     (m_remaining),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: ends the run after too long without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("round_robin_quantum_scheduler verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, fast stretches, and two long hold-offs
    initial begin : result_sink
        int  gap;
        int  results_taken;
        bit  sink_fast;
        results_taken = 0;
        sink_fast     = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (results_taken % 40 == 0)
                sink_fast = ($urandom_range(0, 2) == 0);
            // long hold so the output register stays occupied and the block stalls its input
            if (results_taken == 150 || results_taken == 900) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = sink_fast ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
            @(negedge aclk);
        end
    end

    // One input transfer after a random gap; returns at a falling edge
    task automatic send_item(input logic op, input logic [ID_W-1:0] pid,
                             input logic [RT_W-1:0] rt);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_process_id <= pid;
        s_run_time   <= rt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop offering items and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_quantum(input logic [QUANT_W-1:0] q);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random item: short jobs with occasional create bursts, or long jobs mostly ticking
    task automatic send_random(input int create_pct, input bit long_jobs);
        logic            op;
        logic [RT_W-1:0] rt;
        int              pick;
        if (burst_left > 0) begin
            op = OP_CREATE;
            burst_left--;
        end else if (!long_jobs && $urandom_range(0, 99) < 3) begin
            op         = OP_CREATE;
            burst_left = 17;
        end else begin
            op = ($urandom_range(0, 99) < create_pct) ? OP_CREATE : OP_TICK;
        end
        pick = $urandom_range(0, 99);
        if (long_jobs && pick < 80)
            rt = RT_W'($urandom_range(150, 400));
        else if (pick < 5)
            rt = '0;
        else if (pick < 8)
            rt = '1;
        else if (pick < 14)
            rt = RT_W'($urandom());
        else
            rt = RT_W'($urandom_range(1, 12));
        send_item(op, ID_W'($urandom_range(0, 15)), rt);
    endtask

    task automatic run_phase(input logic [QUANT_W-1:0] q, input int count,
                             input int create_pct, input bit long_jobs);
        write_quantum(q);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                sender_fast = ($urandom_range(0, 2) == 0);
            send_random(create_pct, long_jobs);
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [RT_W-1:0] rt;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset quantum of 3
        send_item(OP_TICK, ID_W'(9), RT_W'(16'h1234));
        send_item(OP_CREATE, '1, '1);
        // fill the queue: instant finish, finish on expiry tick, zero run time first
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            rt = (i == 0) ? RT_W'(1) : (i == 1) ? RT_W'(3) : (i == 2) ? '0 : RT_W'(i * 7 + 2);
            send_item(OP_CREATE, ID_W'(i), rt);
        end
        send_item(OP_CREATE, ID_W'(5), RT_W'(16'h00FF));
        // preempt, then finish, finish with expiry on the same tick, zero-time finish
        repeat (8) send_item(OP_TICK, '0, '0);

        run_phase(QUANT_W'(1), 200, 50, 1'b0);
        run_phase('1, 400, 8, 1'b1);
        run_phase('0, 400, 8, 1'b1);
        run_phase(QUANT_W'(2), 200, 45, 1'b0);
        run_phase(QUANT_W'($urandom_range(1, 254)), 200, 50, 1'b0);
        run_phase(QUANTUM_RESET, 100, 50, 1'b0);

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("round_robin_quantum_scheduler verification clean");
        end else begin
            $display("round_robin_quantum_scheduler verification failed");
        end
        $finish;
    end

endmodule
